// ===== design/psrl_pkg.sv =====
// ----------------------------------------------------------------------------
// psrl_pkg
// Shared types and constants of the per-source connection rate limiter.
// ----------------------------------------------------------------------------
package psrl_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes (byte address bits 3:2)
   localparam logic [1:0] REG_RATE_LIMIT = 2'd0;
   localparam logic [1:0] REG_WINDOW_MS  = 2'd1;
   localparam logic [1:0] REG_IDLE_MS    = 2'd2;

   localparam logic [15:0] RATE_LIMIT_RST = 16'd10;
   localparam logic [15:0] WINDOW_MS_RST  = 16'd1000;
   localparam logic [23:0] IDLE_MS_RST    = 24'd60000;

   localparam logic [1:0] VERDICT_ALLOWED = 2'd0;
   localparam logic [1:0] VERDICT_LIMITED = 2'd1;
   localparam logic [1:0] VERDICT_FULL    = 2'd2;

   typedef struct packed {
      logic        is_ipv6;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [15:0] source_count;
      logic [31:0] rejected_total;
   } rsp_type;

   typedef struct packed {
      logic [15:0] rate_limit;
      logic [15:0] window_ms;
      logic [23:0] idle_ms;
   } cfg_type;

   typedef struct packed {
      logic        family;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [31:0] start;
      logic [15:0] count;
   } entry_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic decide;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic last_issue;
   } status_type;

endpackage

// ===== design/per_source_connection_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// per_source_connection_rate_limiter
// Fixed-window connection rate limiter keyed by IPv4/IPv6 source address.
// ----------------------------------------------------------------------------
// Usage
//   An attempt (req_data) is taken at a rising edge with start high and busy
//   low. Its result (rsp_data) is registered at the end of the update state,
//   after the scan, drain and decision states, and sits on the result ports
//   for one cycle with rsp_valid high. The receiver cannot stall the block;
//   each result must be taken in the cycle it is shown.
//   busy falls as the result is registered, so a new attempt can be taken in
//   the cycle the result is shown, but not while one is still in progress.
//   The scan reads the source table one entry per cycle through the single
//   read port of the entry memory; drain, decision and update states follow.
//   Idle entries left by an allowed attempt are freed as the next scan
//   passes them.
//   Registers rate_limit, window_ms and idle_ms sit at byte addresses 0, 4
//   and 8 of the APB-style port; write them only while the block is idle.
//   Reset empties the table, clears the reject counter and restores the
//   register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_source_connection_rate_limiter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  psrl_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output psrl_pkg::rsp_type                rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [psrl_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [psrl_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [psrl_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   psrl_pkg::cfg_type    cfg;
   psrl_pkg::cmd_type    cmd;
   psrl_pkg::status_type status;

   psrl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   psrl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   psrl_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // an accepted transaction keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
   else $error("busy did not rise after an accepted transaction");

   // a result is registered only by the update step
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.update))
   else $error("result strobe without an update step");

   // a table-full verdict carries no count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.verdict == psrl_pkg::VERDICT_FULL)
      |-> rsp_data.source_count == 16'd0)
   else $error("table-full result with nonzero count");

   // a rate-limited result always shows a nonzero reject total
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.verdict == psrl_pkg::VERDICT_LIMITED)
      |-> rsp_data.rejected_total != 32'd0)
   else $error("rate-limited result with zero reject total");

endmodule

// ===== design/psrl_csr.sv =====
// ----------------------------------------------------------------------------
// psrl_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module psrl_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [psrl_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [psrl_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [psrl_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output psrl_pkg::cfg_type                cfg
);

   psrl_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            psrl_pkg::REG_RATE_LIMIT: cfg_in.rate_limit = pwdata[15:0];
            psrl_pkg::REG_WINDOW_MS:  cfg_in.window_ms  = pwdata[15:0];
            psrl_pkg::REG_IDLE_MS:    cfg_in.idle_ms    = pwdata[23:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_limit <= psrl_pkg::RATE_LIMIT_RST;
         cfg_ff.window_ms  <= psrl_pkg::WINDOW_MS_RST;
         cfg_ff.idle_ms    <= psrl_pkg::IDLE_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         psrl_pkg::REG_RATE_LIMIT: prdata = {16'd0, cfg_ff.rate_limit};
         psrl_pkg::REG_WINDOW_MS:  prdata = {16'd0, cfg_ff.window_ms};
         psrl_pkg::REG_IDLE_MS:    prdata = {8'd0, cfg_ff.idle_ms};
         default:                  prdata = '0;
      endcase
   end

endmodule

// ===== design/psrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// psrl_ctrl
// Sequencer: table scan, drain, decision and update of one attempt.
// ----------------------------------------------------------------------------
module psrl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  psrl_pkg::status_type status,
   output psrl_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         // last read comes back and is evaluated here
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/psrl_datapath.sv =====
// ----------------------------------------------------------------------------
// psrl_datapath
// Source table memory, valid bits, scan evaluation and entry update.
// ----------------------------------------------------------------------------
module psrl_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  psrl_pkg::cmd_type    cmd,
   output psrl_pkg::status_type status,
   input  psrl_pkg::req_type    req_data,
   input  psrl_pkg::cfg_type    cfg,
   output logic                 rsp_valid,
   output psrl_pkg::rsp_type    rsp_data
);

   localparam int N = psrl_pkg::TABLE_ENTRIES;
   localparam int W = psrl_pkg::IDX_W;

   psrl_pkg::entry_type mem [N];
   psrl_pkg::entry_type rd_data_ff;

   logic [N-1:0]  valid_ff;

   // captured key and time of the current transaction
   logic          key_fam_ff;
   logic [63:0]   key_hi_ff;
   logic [63:0]   key_lo_ff;
   logic [31:0]   now_ff;

   // scan
   logic [W-1:0]  idx_ff;
   logic          ev_ff;
   logic [W-1:0]  ev_idx_ff;
   logic          ev_valid_ff;
   logic          found_ff;
   logic [W-1:0]  found_idx_ff;
   logic [31:0]   found_start_ff;
   logic [15:0]   found_count_ff;
   logic          spare_ff;
   logic [W-1:0]  spare_idx_ff;

   // deferred idle freeing left by the last allowed transaction
   logic          pend_ff;
   logic [31:0]   pend_now_ff;
   logic [23:0]   pend_idle_ff;

   // decision
   logic          have_slot_ff;
   logic [W-1:0]  upd_slot_ff;
   logic [31:0]   upd_start_ff;
   logic [15:0]   upd_count_ff;

   logic [31:0]   rej_ff;
   logic          rsp_valid_ff;
   psrl_pkg::rsp_type rsp_ff;

   logic          ev_free;
   logic          ev_live;
   logic          ev_match;
   logic [31:0]   ev_age;
   logic [31:0]   found_age;
   logic          win_expired;
   logic          over_limit;
   logic [15:0]   count_inc;
   logic [31:0]   rej_inc;
   psrl_pkg::entry_type wr_entry;

   assign status.last_issue = (idx_ff == W'(N - 1));
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_ff;

   assign ev_age   = pend_now_ff - rd_data_ff.start;
   assign ev_free  = pend_ff && (rd_data_ff.count == 16'd0) && (ev_age > {8'd0, pend_idle_ff});
   assign ev_live  = ev_valid_ff && !ev_free;
   assign ev_match = (rd_data_ff.family == key_fam_ff) && (rd_data_ff.addr_high == key_hi_ff)
                     && (rd_data_ff.addr_low == key_lo_ff);

   assign found_age   = now_ff - found_start_ff;
   assign win_expired = (found_age >= {16'd0, cfg.window_ms});

   assign over_limit = (upd_count_ff >= cfg.rate_limit);
   assign count_inc  = upd_count_ff + 16'd1;
   assign rej_inc    = (rej_ff == 32'hFFFF_FFFF) ? rej_ff : rej_ff + 32'd1;

   always_comb begin
      wr_entry.family    = key_fam_ff;
      wr_entry.addr_high = key_hi_ff;
      wr_entry.addr_low  = key_lo_ff;
      wr_entry.start     = upd_start_ff;
      wr_entry.count     = over_limit ? upd_count_ff : count_inc;
   end

   // entry memory: one read and one write port
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_data_ff <= mem[idx_ff];
      end
      if (cmd.update && have_slot_ff) begin
         mem[upd_slot_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_fam_ff <= req_data.is_ipv6;
         key_hi_ff  <= req_data.is_ipv6 ? req_data.addr_high : 64'd0;
         key_lo_ff  <= req_data.is_ipv6 ? req_data.addr_low
                                        : {32'd0, req_data.addr_low[31:0]};
         now_ff     <= req_data.now_ms;
      end
      if (cmd.issue) begin
         ev_idx_ff   <= idx_ff;
         ev_valid_ff <= valid_ff[idx_ff];
      end
      if (ev_ff && ev_live && ev_match && !found_ff) begin
         found_idx_ff   <= ev_idx_ff;
         found_start_ff <= rd_data_ff.start;
         found_count_ff <= rd_data_ff.count;
      end
      if (ev_ff && !ev_live && !spare_ff) begin
         spare_idx_ff <= ev_idx_ff;
      end
      if (cmd.decide) begin
         if (found_ff) begin
            upd_slot_ff  <= found_idx_ff;
            upd_start_ff <= win_expired ? now_ff : found_start_ff;
            upd_count_ff <= win_expired ? 16'd0 : found_count_ff;
         end else begin
            upd_slot_ff  <= spare_idx_ff;
            upd_start_ff <= now_ff;
            upd_count_ff <= 16'd0;
         end
      end
      if (cmd.update) begin
         pend_now_ff  <= now_ff;
         pend_idle_ff <= cfg.idle_ms;
         if (!have_slot_ff) begin
            rsp_ff.verdict        <= psrl_pkg::VERDICT_FULL;
            rsp_ff.source_count   <= 16'd0;
            rsp_ff.rejected_total <= rej_ff;
         end else if (over_limit) begin
            rsp_ff.verdict        <= psrl_pkg::VERDICT_LIMITED;
            rsp_ff.source_count   <= upd_count_ff;
            rsp_ff.rejected_total <= rej_inc;
         end else begin
            rsp_ff.verdict        <= psrl_pkg::VERDICT_ALLOWED;
            rsp_ff.source_count   <= count_inc;
            rsp_ff.rejected_total <= rej_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         idx_ff       <= '0;
         ev_ff        <= 1'b0;
         found_ff     <= 1'b0;
         spare_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         have_slot_ff <= 1'b0;
         rej_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ev_ff        <= cmd.issue;
         rsp_valid_ff <= cmd.update;
         if (cmd.load) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
            spare_ff <= 1'b0;
         end else if (cmd.issue) begin
            idx_ff <= idx_ff + W'(1);
         end
         // an idle zero-count entry is freed as the scan passes it
         if (ev_ff && ev_valid_ff && ev_free) begin
            valid_ff[ev_idx_ff] <= 1'b0;
         end
         if (ev_ff && ev_live && ev_match) begin
            found_ff <= 1'b1;
         end
         if (ev_ff && !ev_live) begin
            spare_ff <= 1'b1;
         end
         if (cmd.decide) begin
            have_slot_ff <= found_ff || spare_ff;
         end
         if (cmd.update) begin
            pend_ff <= have_slot_ff && !over_limit;
            if (have_slot_ff) begin
               valid_ff[upd_slot_ff] <= 1'b1;
               if (over_limit) begin
                  rej_ff <= rej_inc;
               end
            end
         end
      end
   end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-source connection rate limiter. Attempts
// drawn from small pools of IPv4/IPv6 sources are queued and driven in bursts
// with random gaps. An internal predictor of the source table models every
// verdict, and each result is checked field by field as it is strobed out.
// The table is flushed by register writes and attempts between phases of
// differing limits, so it can fill and drain again many times over.
// ----------------------------------------------------------------------------
module tb;

   localparam int STALL_LIMIT = 1000;
   localparam int POOL_MAX    = 128;

   logic                            clock   = 1'b0;
   logic                            reset   = 1'b1;
   logic                            start   = 1'b0;
   logic                            busy;
   psrl_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   psrl_pkg::rsp_type               rsp_data;
   logic                            psel    = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite  = 1'b0;
   logic [psrl_pkg::CSR_ADDR_W-1:0] paddr   = '0;
   logic [psrl_pkg::CSR_DATA_W-1:0] pwdata  = '0;
   logic [psrl_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   per_source_connection_rate_limiter uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted source table and limits
   logic        src_valid  [psrl_pkg::TABLE_ENTRIES];
   logic        src_family [psrl_pkg::TABLE_ENTRIES];
   logic [63:0] src_hi     [psrl_pkg::TABLE_ENTRIES];
   logic [63:0] src_lo     [psrl_pkg::TABLE_ENTRIES];
   logic [31:0] src_start  [psrl_pkg::TABLE_ENTRIES];
   logic [15:0] src_count  [psrl_pkg::TABLE_ENTRIES];
   logic [31:0] reject_total = '0;
   logic [15:0] cfg_rate     = psrl_pkg::RATE_LIMIT_RST;
   logic [15:0] cfg_window   = psrl_pkg::WINDOW_MS_RST;
   logic [23:0] cfg_idle     = psrl_pkg::IDLE_MS_RST;

   psrl_pkg::req_type attempt_queue[$];
   psrl_pkg::rsp_type verdict_queue[$];
   int      attempts_queued = 0;
   int      results_seen    = 0;
   int      errors          = 0;
   int      stall_cycles    = 0;
   int      burst_left      = 1;
   int      gap_left        = 0;

   logic        pool_fam [POOL_MAX];
   logic [63:0] pool_hi  [POOL_MAX];
   logic [63:0] pool_lo  [POOL_MAX];
   logic [31:0] now_cursor;

   initial begin
      for (int i = 0; i < psrl_pkg::TABLE_ENTRIES; i++) begin
         src_valid[i] = 1'b0;
      end
   end

   function automatic psrl_pkg::rsp_type rate_check(input psrl_pkg::req_type a);
      logic        fam;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [31:0] now;
      logic [31:0] age;
      int          slot;
      int          spare;
      psrl_pkg::rsp_type r;
      fam   = a.is_ipv6;
      hi    = fam ? a.addr_high : 64'd0;
      lo    = fam ? a.addr_low : {32'd0, a.addr_low[31:0]};
      now   = a.now_ms;
      slot  = -1;
      spare = -1;
      for (int i = 0; i < psrl_pkg::TABLE_ENTRIES; i++) begin
         if (src_valid[i]) begin
            if (slot < 0 && src_family[i] == fam && src_hi[i] == hi && src_lo[i] == lo)
               slot = i;
         end else if (spare < 0) begin
            spare = i;
         end
      end
      if (slot < 0 && spare < 0) begin
         r.verdict        = psrl_pkg::VERDICT_FULL;
         r.source_count   = '0;
         r.rejected_total = reject_total;
         return r;
      end
      if (slot < 0) begin
         slot             = spare;
         src_valid[slot]  = 1'b1;
         src_family[slot] = fam;
         src_hi[slot]     = hi;
         src_lo[slot]     = lo;
         src_start[slot]  = now;
         src_count[slot]  = '0;
      end
      age = now - src_start[slot];
      if (age >= {16'd0, cfg_window}) begin
         src_start[slot] = now;
         src_count[slot] = '0;
      end
      if (src_count[slot] >= cfg_rate) begin
         if (reject_total != 32'hFFFF_FFFF)
            reject_total = reject_total + 32'd1;
         r.verdict = psrl_pkg::VERDICT_LIMITED;
      end else begin
         src_count[slot] = src_count[slot] + 16'd1;
         // zero-count entries idle past the limit are released
         for (int i = 0; i < psrl_pkg::TABLE_ENTRIES; i++) begin
            age = now - src_start[i];
            if (src_valid[i] && src_count[i] == 16'd0 && age > {8'd0, cfg_idle})
               src_valid[i] = 1'b0;
         end
         r.verdict = psrl_pkg::VERDICT_ALLOWED;
      end
      r.source_count   = src_count[slot];
      r.rejected_total = reject_total;
      return r;
   endfunction

   // driver: bursts of transactions with random gaps between them
   always @(posedge clock) begin : drive
      logic fire;
      fire = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (fire) begin
            verdict_queue.push_back(rate_check(req_data));
         end
         if (!start || fire) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               start <= 1'b0;
            end else if (attempt_queue.size() != 0) begin
               req_data <= attempt_queue.pop_front();
               start    <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      psrl_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         results_seen = results_seen + 1;
         if (verdict_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors = errors + 1;
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_data.verdict !== want.verdict) begin
               $display("%0t: verdict expected %0d actual %0d",
                        $time, want.verdict, rsp_data.verdict);
               errors = errors + 1;
            end
            if (rsp_data.source_count !== want.source_count) begin
               $display("%0t: source_count expected %0d actual %0d",
                        $time, want.source_count, rsp_data.source_count);
               errors = errors + 1;
            end
            if (rsp_data.rejected_total !== want.rejected_total) begin
               $display("%0t: rejected_total expected %0d actual %0d",
                        $time, want.rejected_total, rsp_data.rejected_total);
               errors = errors + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   task automatic push_attempt(input logic fam, input logic [63:0] hi, input logic [63:0] lo,
                               input logic [31:0] now);
      psrl_pkg::req_type a;
      a.is_ipv6   = fam;
      a.addr_high = hi;
      a.addr_low  = lo;
      a.now_ms    = now;
      attempt_queue.push_back(a);
      attempts_queued = attempts_queued + 1;
   endtask

   task automatic wait_idle();
      while (results_seen != attempts_queued) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         psrl_pkg::REG_RATE_LIMIT: cfg_rate   = data[15:0];
         psrl_pkg::REG_WINDOW_MS:  cfg_window = data[15:0];
         psrl_pkg::REG_IDLE_MS:    cfg_idle   = data[23:0];
         default: ;
      endcase
   endtask

   // unused upper data bits carry noise, the register keeps only its width
   task automatic set_limits(input logic [15:0] rate, input logic [15:0] window,
                             input logic [23:0] idle);
      wait_idle();
      csr_write(psrl_pkg::REG_RATE_LIMIT, {16'($urandom), rate});
      csr_write(psrl_pkg::REG_WINDOW_MS, {16'($urandom), window});
      csr_write(psrl_pkg::REG_IDLE_MS, {8'($urandom), idle});
   endtask

   // zero every resident count, then one allowed transaction with no idle
   // allowance releases all the other entries
   task automatic flush_table();
      logic [31:0] t;
      int          first;
      set_limits(16'd0, 16'd1, cfg_idle);
      t     = now_cursor + 32'd5000;
      first = -1;
      for (int i = 0; i < psrl_pkg::TABLE_ENTRIES; i++) begin
         if (src_valid[i]) begin
            push_attempt(src_family[i], src_hi[i], src_lo[i], t);
            if (first < 0) first = i;
         end
      end
      if (first >= 0) begin
         set_limits(16'd1, 16'd1, 24'd0);
         push_attempt(src_family[first], src_hi[first], src_lo[first], t + 32'd10);
      end
      now_cursor = t + 32'd10;
      wait_idle();
   endtask

   task automatic new_pool(input int n, input int v6_pct);
      for (int p = 0; p < n; p++) begin
         pool_fam[p] = ($urandom_range(0, 99) < v6_pct);
         pool_hi[p]  = {$urandom, $urandom};
         pool_lo[p]  = {$urandom, $urandom};
         if (p == 0) begin
            pool_hi[p] = '1;
            pool_lo[p] = '1;
         end else if (p == 1) begin
            pool_hi[p] = '0;
            pool_lo[p] = '0;
         end
         if (!pool_fam[p]) begin
            pool_hi[p]        = '0;
            pool_lo[p][63:32] = '0;
         end
      end
   endtask

   task automatic run_phase(input int n, input int pool_n, input int max_step);
      int          p;
      logic [63:0] hi;
      logic [63:0] lo;
      for (int k = 0; k < n; k++) begin
         now_cursor = now_cursor + $urandom_range(0, max_step);
         if ($urandom_range(0, 49) == 0) now_cursor = now_cursor + $urandom;
         if ($urandom_range(0, 99) < 8) begin
            push_attempt(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, now_cursor);
         end else begin
            p  = $urandom_range(0, pool_n - 1);
            hi = pool_hi[p];
            lo = pool_lo[p];
            // ipv4 bits outside the key must not matter
            if (!pool_fam[p] && $urandom_range(0, 3) == 0) begin
               hi        = {$urandom, $urandom};
               lo[63:32] = $urandom;
            end
            push_attempt(pool_fam[p], hi, lo, now_cursor);
         end
      end
   endtask

   initial begin
      int          pool_n;
      logic [15:0] rate;
      logic [15:0] window;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: key forms and address extremes under the reset limits
      push_attempt(1'b0, 64'd0, 64'h0000_0000_C0A8_0001, 32'd0);
      push_attempt(1'b0, '1, 64'hFFFF_FFFF_C0A8_0001, 32'd1);
      push_attempt(1'b1, 64'd0, 64'h0000_0000_C0A8_0001, 32'd2);
      push_attempt(1'b1, '1, '1, 32'hFFFF_FFFF);
      push_attempt(1'b0, 64'd0, 64'd0, 32'hFFFF_FFFF);
      push_attempt(1'b1, 64'd0, 64'd0, 32'd0);
      push_attempt(1'b0, 64'd0, 64'h0000_0000_FFFF_FFFF, 32'd999);
      push_attempt(1'b0, 64'd0, 64'h0000_0000_C0A8_0001, 32'd1000);
      // limit reached, then the window rolls over
      set_limits(16'd2, 16'd100, psrl_pkg::IDLE_MS_RST);
      repeat (3) push_attempt(1'b1, 64'h2001_0DB8_0000_0000, 64'd1, 32'd2000);
      push_attempt(1'b1, 64'h2001_0DB8_0000_0000, 64'd1, 32'd2099);
      push_attempt(1'b1, 64'h2001_0DB8_0000_0000, 64'd1, 32'd2100);
      // zero limit: every transaction rejected, entries kept with zero count
      set_limits(16'd0, 16'hFFFF, 24'hFF_FFFF);
      push_attempt(1'b0, 64'd0, 64'h0000_0000_0A00_0001, 32'd3000);
      push_attempt(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 32'd3000);
      // zero window and zero idle time
      set_limits(16'hFFFF, 16'd0, 24'd0);
      push_attempt(1'b1, 64'h2001_0DB8_0000_0000, 64'd1, 32'd3001);
      push_attempt(1'b0, 64'd0, 64'h0000_0000_0A00_0001, 32'd3002);
      push_attempt(1'b1, 64'h2001_0DB8_0000_0000, 64'd1, 32'd3002);
      now_cursor = 32'd3002;
      flush_table();

      now_cursor = $urandom;
      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: begin
               set_limits(psrl_pkg::RATE_LIMIT_RST, psrl_pkg::WINDOW_MS_RST,
                          psrl_pkg::IDLE_MS_RST);
               new_pool(40, 50); run_phase(110, 40, 60); end
            1: begin set_limits(16'd3, 16'd50, 24'd200);
                  new_pool(20, 50); run_phase(110, 20, 30); end
            2: begin set_limits(16'hFFFF, 16'hFFFF, 24'hFF_FFFF);
                  new_pool(90, 50); run_phase(110, 90, 1000); end
            3: begin set_limits(16'd1, 16'd1, 24'd1);
                  new_pool(70, 30); run_phase(110, 70, 3); end
            4: begin set_limits(16'd0, 16'd500, 24'd100);
                  new_pool(80, 70); run_phase(110, 80, 20); end
            5: begin set_limits(16'd2, 16'd0, 24'd0);
                  new_pool(30, 50); run_phase(110, 30, 5); end
            default: begin
               rate   = 16'($urandom_range(1, 8));
               window = 16'($urandom_range(1, 3000));
               pool_n = $urandom_range(8, 100);
               set_limits(rate, window, 24'($urandom_range(1, 6000)));
               new_pool(pool_n, $urandom_range(0, 100));
               run_phase(110, pool_n, int'(window) / 8 + 2);
            end
         endcase
         flush_table();
      end

      wait_idle();
      repeat (80) @(posedge clock);
      if (errors == 0 && verdict_queue.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
